>>> rtl/core/bm3_pkg.sv
// Shared constants and types of the 3x3 binary morphology core.
package bm3_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Dimension registers come out of reset at this value, clipped to the maxima.
    localparam int DIM_RESET = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_OPERATION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic OP_ERODE  = 1'b0;
    localparam logic OP_DILATE = 1'b1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    localparam logic [7:0] PIX_SET   = 8'hFF;
    localparam logic [7:0] PIX_CLEAR = 8'h00;

    // Depth of the result queue behind the window stage.
    localparam int OQ_DEPTH = 3;

    typedef struct packed {
        logic [7:0] out_value;
        logic       frame_last;
    } t_result;

endpackage

>>> rtl/core/bm3_if.sv
// Channel interfaces of the 3x3 binary morphology core.
interface bm3_pix_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] pixel_value;

    modport source (output valid, mode, pixel_value, input ready);
    modport sink   (input valid, mode, pixel_value, output ready);
endinterface

interface bm3_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;
    logic       frame_last;

    modport source (output valid, out_value, frame_last, input ready);
    modport sink   (input valid, out_value, frame_last, output ready);
endinterface

interface bm3_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bm3_pkg::CFG_IDX_W-1:0]  index;
    logic [bm3_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/bm3_line_buf.sv
// Two-row line memory, one bit per row per column, with read-after-write forwarding.
module bm3_line_buf #(
    parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [1:0]                   i_wr_data,
    output logic [1:0]                   o_rd_data
);
    import bm3_pkg::*;

    // Bit 1 holds the older row, bit 0 the newer one.
    logic [1:0] r_mem [MAX_WIDTH];
    logic [1:0] r_rd_data;
    logic [1:0] r_fwd_data;
    logic       r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            // A write to the same column in the same cycle is not yet visible in the array.
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

>>> rtl/core/bm3_out_fifo.sv
// Small result queue that decouples the window stage from the output channel.
module bm3_out_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  bm3_pkg::t_result                   i_data,
    output logic [$clog2(bm3_pkg::OQ_DEPTH+1)-1:0] o_count,
    bm3_res_if.source                          o_res
);
    import bm3_pkg::*;

    localparam int PW = $clog2(OQ_DEPTH);
    localparam int NW = $clog2(OQ_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(OQ_DEPTH - 1);

    t_result       r_q [OQ_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          pop;

    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + NW'(i_push) - NW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    assign o_count          = r_count;
    assign o_res.valid      = (r_count != '0);
    assign o_res.out_value  = r_q[r_rd_ptr].out_value;
    assign o_res.frame_last = r_q[r_rd_ptr].frame_last;

endmodule

>>> rtl/core/binary_morphology_3x3_core.sv
// Top level of the streaming 3x3 binary erosion and dilation core.
//
// Mask pixels enter on i_pix in raster order, one per transaction; a nonzero byte is a set
// pixel. Each result on o_res is 0 or 255, and frame_last marks the final pixel of a frame.
// The window is clipped at the frame edges. Result k leaves with the transaction that brings
// input pixel k+W+1; once the frame is complete, each drain transaction (or any further
// pixel) releases the next result, W+1 of them for frames of two or more rows, W for one row.
// i_cfg writes operation, width and height at indexes 0 to 2; each such write restarts the
// frame, a write to index 3 is ignored, and writes are meant to be issued only while the
// core is idle. Its ready is always high.
// Throughput is one transaction per cycle while i_pix.ready is high: each pixel does
// one read and one write of the two-row line memory at its column, a drain only the read,
// and the read data is consumed the cycle after. A result is pushed into the result queue
// in the cycle after the transaction that releases it and can be taken once it is queued.
// A three-entry result queue absorbs receiver stalls; i_pix.ready drops only when that
// queue and the window stage together hold three results.
// Reset returns the core to the start of a frame with erosion and the largest frame size.
// The line memory needs no clearing pass: stale rows only ever fall outside the window.
module binary_morphology_3x3_core #(
    parameter int MAX_WIDTH  = bm3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bm3_pkg::MAX_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bm3_pix_if.sink   i_pix,
    bm3_res_if.source o_res,
    bm3_cfg_if.sink   i_cfg
);
    import bm3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int NW = $clog2(OQ_DEPTH + 1);
    localparam logic [WW-1:0] RST_W = WW'((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET);
    localparam logic [HW-1:0] RST_H = HW'((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET);

    // Configuration
    logic          r_operation;
    logic [WW-1:0] r_eff_w;
    logic [HW-1:0] r_eff_h;
    logic          cfg_wr;
    logic          cfg_restart;

    // Input position; rows at and past the height are drain positions
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] n_in_row;
    logic [CW-1:0] n_in_col;

    // Window stage
    logic          r_s1_valid;
    logic          r_s1_emit;
    logic          r_s1_last;
    logic          r_s1_wr;
    logic          r_s1_cap;
    logic          r_s1_first;
    logic          r_s1_bit;
    logic [CW-1:0] r_s1_addr;
    logic [8:0]    r_s1_mask;
    logic [2:0]    r_sh_old;
    logic [2:0]    r_sh_new;
    logic          r_first_bit;

    logic          acc;
    logic          in_done;
    logic          op_real;
    logic          op_drain;
    logic          op_any;
    logic          col_is0;
    logic          col_end;
    logic          op_emit;
    logic          op_last;
    logic          op_first;
    logic          row_top;
    logic          row_bot;
    logic          col_left;
    logic          col_right;
    logic [2:0]    row_mask;
    logic [8:0]    op_mask;
    logic [RW-1:0] h_ext;
    logic [CW-1:0] w_last;

    logic [1:0]    lb_rd_data;
    logic [2:0]    col_r;
    logic [2:0]    col_c;
    logic [8:0]    win;
    logic          res_bit;
    logic          s1_push;
    t_result       s1_res;
    logic [NW-1:0] oq_count;

    assign h_ext  = RW'(r_eff_h);
    assign w_last = CW'(r_eff_w - WW'(1));

    assign s1_push     = r_s1_valid && r_s1_emit;
    assign i_pix.ready = ((NW+1)'(oq_count) + (NW+1)'(s1_push)) < (NW+1)'(OQ_DEPTH);
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign cfg_restart = cfg_wr && ((i_cfg.index == REG_OPERATION)
                                    || (i_cfg.index == REG_IMAGE_WIDTH)
                                    || (i_cfg.index == REG_IMAGE_HEIGHT));

    assign acc      = i_pix.valid && i_pix.ready;
    assign in_done  = (r_in_row >= h_ext);
    assign op_real  = acc && (i_pix.mode == MODE_PIXEL) && !in_done;
    assign op_drain = acc && in_done;
    assign op_any   = op_real || op_drain;
    assign col_is0  = (r_in_col == '0);
    assign col_end  = (r_in_col == w_last);

    // At column 0 the item completes the last pixel of the row two above; elsewhere it
    // completes the pixel one row up and one column left.
    assign op_emit  = op_drain || (col_is0 ? (r_in_row >= RW'(2)) : (r_in_row >= RW'(1)));
    assign op_last  = op_drain && (r_in_row == h_ext + RW'(1));
    // A one-row frame drains from column 1, and a one-pixel frame from its final drain
    // position, so the centre column of that first result comes from a held bit.
    assign op_first = op_drain && (r_eff_h == HW'(1))
                      && ((r_eff_w == WW'(1))
                          || ((r_in_row == RW'(1)) && (r_in_col == CW'(1))));

    always_comb begin
        if (col_is0) begin
            row_top   = (r_in_row >= RW'(3));
            row_bot   = (r_in_row <= h_ext);
            col_left  = (r_eff_w >= WW'(2));
            col_right = 1'b0;
        end else begin
            row_top   = (r_in_row >= RW'(2));
            row_bot   = !in_done;
            col_left  = (r_in_col >= CW'(2));
            col_right = 1'b1;
        end
        row_mask = {row_top, 1'b1, row_bot};
        op_mask  = {col_left ? row_mask : 3'b000, row_mask, col_right ? row_mask : 3'b000};
    end

    always_comb begin
        n_in_row = r_in_row;
        n_in_col = r_in_col;
        if (cfg_restart || op_last) begin
            n_in_row = '0;
            n_in_col = '0;
        end else if (op_any) begin
            if (!col_end) begin
                n_in_col = r_in_col + CW'(1);
            end else if (op_real && (r_eff_h == HW'(1))) begin
                // End of a one-row frame: skip the drain position that releases nothing.
                if (r_eff_w == WW'(1)) begin
                    n_in_row = RW'(2);
                    n_in_col = '0;
                end else begin
                    n_in_row = RW'(1);
                    n_in_col = CW'(1);
                end
            end else begin
                n_in_row = r_in_row + RW'(1);
                n_in_col = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= OP_ERODE;
            r_eff_w     <= RST_W;
            r_eff_h     <= RST_H;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_s1_valid <= op_any;
            if (cfg_wr) begin
                unique case (i_cfg.index)
                    REG_OPERATION: begin
                        r_operation <= i_cfg.data[0];
                    end
                    REG_IMAGE_WIDTH: begin
                        if (i_cfg.data == '0) begin
                            r_eff_w <= WW'(1);
                        end else if (32'(i_cfg.data) > MAX_WIDTH) begin
                            r_eff_w <= WW'(MAX_WIDTH);
                        end else begin
                            r_eff_w <= WW'(i_cfg.data);
                        end
                    end
                    REG_IMAGE_HEIGHT: begin
                        if (i_cfg.data == '0) begin
                            r_eff_h <= HW'(1);
                        end else if (32'(i_cfg.data) > MAX_HEIGHT) begin
                            r_eff_h <= HW'(MAX_HEIGHT);
                        end else begin
                            r_eff_h <= HW'(i_cfg.data);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (op_any) begin
            r_s1_emit  <= op_emit;
            r_s1_last  <= op_last;
            r_s1_wr    <= op_real;
            r_s1_cap   <= op_real && col_is0;
            r_s1_first <= op_first;
            r_s1_bit   <= (i_pix.pixel_value != PIX_CLEAR);
            r_s1_addr  <= r_in_col;
            r_s1_mask  <= op_mask;
        end
        if (r_s1_valid) begin
            r_sh_old <= col_c;
            r_sh_new <= col_r;
            if (r_s1_cap) begin
                r_first_bit <= r_s1_bit;
            end
        end
    end

    bm3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (op_any),
        .i_rd_addr (r_in_col),
        .i_wr_en   (r_s1_valid && r_s1_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({lb_rd_data[0], r_s1_bit}),
        .o_rd_data (lb_rd_data)
    );

    // Each column is {row two up, row one up, current row}.
    assign col_r = {lb_rd_data, r_s1_bit};
    assign col_c = r_s1_first ? {1'b0, r_first_bit, 1'b0} : r_sh_new;
    assign win   = {r_sh_old, col_c, col_r};

    always_comb begin
        if (r_operation == OP_DILATE) begin
            res_bit = |(win & r_s1_mask);
        end else begin
            res_bit = &(win | ~r_s1_mask);
        end
        s1_res.out_value  = res_bit ? PIX_SET : PIX_CLEAR;
        s1_res.frame_last = r_s1_last;
    end

    bm3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_push),
        .i_data  (s1_res),
        .o_count (oq_count),
        .o_res   (o_res)
    );

`ifndef ASSERT_OFF
    a_result_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.out_value == PIX_SET || o_res.out_value == PIX_CLEAR))
        else $error("result value is neither 0 nor 255");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_last |=> (r_in_row == '0 && r_in_col == '0 && r_s1_last && r_s1_emit))
        else $error("frame position not restarted after the final result");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_in_col) < 32'(r_eff_w))
        else $error("input column beyond the frame width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= h_ext + RW'(1))
        else $error("input row beyond the drain rows");
`endif

endmodule

>>> tb/sv/binary_morphology_3x3_core_tb.sv
// Self-checking testbench for the streaming 3x3 binary erosion and dilation core.
module binary_morphology_3x3_core_tb;
    import bm3_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int MASK_DEPTH       = 16384;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 40;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int RANDOM_ITEMS     = 320;
    localparam int PRINT_LIMIT      = 40;
    localparam int TIMEOUT_UNITS    = 40_000_000;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] value;
    } t_pix_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bm3_pix_if pix_if ();
    bm3_res_if res_if ();
    bm3_cfg_if cfg_if ();

    binary_morphology_3x3_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_pix_item pixels_to_send[$];
    t_result   expected_out_pixels[$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int stream_items   = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int tx_gap         = 0;
    int rx_gap         = 0;
    bit no_idle        = 1'b0;

    // Shadow of the core: registers, frame positions and the pixels of the current frame.
    logic                  cfg_op;
    logic [CFG_DATA_W-1:0] cfg_width;
    logic [CFG_DATA_W-1:0] cfg_height;
    int                    in_row, in_col, out_row, out_col;
    bit                    frame_mask [0:MASK_DEPTH-1];

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    initial begin
        #TIMEOUT_UNITS;
        $display("binary_morphology_3x3_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void restart_positions();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic int clip_dim(input logic [CFG_DATA_W-1:0] raw, input int limit);
        if (raw == 0) return 1;
        if (raw > limit) return limit;
        return int'(raw);
    endfunction

    function automatic void apply_register_write(input logic [CFG_IDX_W-1:0]  idx,
                                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_OPERATION:    cfg_op = data[0];
            REG_IMAGE_WIDTH:  cfg_width = data;
            REG_IMAGE_HEIGHT: cfg_height = data;
            default:          return;
        endcase
        restart_positions();
    endfunction

    // Erosion or dilation over the window around the next output pixel, clipped to the frame.
    function automatic logic [7:0] window_morph_value(input int w, input int h);
        int r0, r1, c0, c1, r, c;
        bit all_set, any_set;
        r0 = (out_row == 0) ? 0 : out_row - 1;
        r1 = (out_row + 1 >= h) ? h - 1 : out_row + 1;
        c0 = (out_col == 0) ? 0 : out_col - 1;
        c1 = (out_col + 1 >= w) ? w - 1 : out_col + 1;
        all_set = 1'b1;
        any_set = 1'b0;
        for (r = r0; r <= r1; r++) begin
            for (c = c0; c <= c1; c++) begin
                if (frame_mask[r * w + c]) any_set = 1'b1;
                else all_set = 1'b0;
            end
        end
        if (cfg_op == OP_DILATE) return any_set ? PIX_SET : PIX_CLEAR;
        return all_set ? PIX_SET : PIX_CLEAR;
    endfunction

    function automatic void predict_output_pixel(input logic mode, input logic [7:0] value);
        int w, h, total, received, out_idx;
        bit in_done, emit;
        t_result res;
        w        = clip_dim(cfg_width, MAX_WIDTH_DEF);
        h        = clip_dim(cfg_height, MAX_HEIGHT_DEF);
        total    = w * h;
        in_done  = (in_row >= h);
        received = in_done ? total : in_row * w + in_col;
        out_idx  = out_row * w + out_col;
        if (mode == MODE_PIXEL && !in_done) begin
            frame_mask[received] = (value != 8'd0);
            received++;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            emit = (received >= out_idx + w + 2);
        end else begin
            // Drains before the frame is complete do nothing; afterwards any item releases one.
            emit = in_done && (out_idx < total);
        end
        if (!emit) return;
        res.out_value  = window_morph_value(w, h);
        res.frame_last = (out_idx + 1 == total);
        expected_out_pixels = {expected_out_pixels, res};
        if (res.frame_last) begin
            restart_positions();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic void push_item(input logic mode, input logic [7:0] value);
        t_pix_item item;
        item.mode  = mode;
        item.value = value;
        pixels_to_send = {pixels_to_send, item};
    endfunction

    function automatic logic [7:0] draw_mask_byte(input int set_pct);
        if ($urandom_range(0, 99) < set_pct) return 8'($urandom_range(1, 255));
        return PIX_CLEAR;
    endfunction

    task automatic wait_idle();
        while (pixels_to_send.size() != 0 || pix_if.valid) @(posedge i_clk);
        while (expected_out_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
    endtask

    // One whole frame followed by exactly the drains that flush it, with some noise drains
    // while the frame is still open and some pixels standing in for drains afterwards.
    task automatic queue_frame(input int w, input int h, input int set_pct,
                               input bit pause_mid, input bit hold_rx);
        int total, drains, k;
        total  = w * h;
        drains = (h > 1) ? w + 1 : w;
        for (k = 0; k < total; k++) begin
            if (k == total / 2) begin
                if (pause_mid) wait_idle();
                if (hold_rx) hold_requests++;
            end
            if ($urandom_range(0, 24) == 0) push_item(MODE_DRAIN, 8'($urandom));
            push_item(MODE_PIXEL, draw_mask_byte(set_pct));
        end
        for (k = 0; k < drains; k++) begin
            push_item(($urandom_range(0, 5) == 0) ? MODE_PIXEL : MODE_DRAIN, 8'($urandom));
        end
        stream_items += total + drains;
    endtask

    // Pixel sender: the valid stays up between back-to-back transactions.
    always @(posedge i_clk) begin : pixel_sender
        t_pix_item nxt;
        if (!i_rst_n) begin
            pix_if.valid       <= 1'b0;
            pix_if.mode        <= MODE_PIXEL;
            pix_if.pixel_value <= PIX_CLEAR;
            tx_gap             <= 0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (tx_gap > 0) begin
                tx_gap       <= tx_gap - 1;
                pix_if.valid <= 1'b0;
            end else if (pixels_to_send.size() != 0) begin
                nxt = pixels_to_send.pop_front();
                pix_if.valid       <= 1'b1;
                pix_if.mode        <= nxt.mode;
                pix_if.pixel_value <= nxt.value;
                if (!no_idle && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 5);
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : long_hold
        if (!i_rst_n) begin
            hold_left    <= 0;
            holds_served <= 0;
        end else if (holds_served != hold_requests) begin
            hold_left    <= LONG_HOLD_CYCLES;
            holds_served <= hold_requests;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_receiver
        bit take;
        if (!i_rst_n) begin
            rx_gap       <= 0;
            res_if.ready <= 1'b0;
        end else begin
            take = 1'b1;
            if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                take = 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                rx_gap <= $urandom_range(0, 4);
                take = 1'b0;
            end
            res_if.ready <= take && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin : transaction_monitor
        t_result want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (expected_out_pixels.size() == 0) begin
                    report_mismatch($sformatf("result %0d (value %0d) with nothing expected",
                                              results_seen, res_if.out_value));
                end else begin
                    want = expected_out_pixels.pop_front();
                    if (res_if.out_value !== want.out_value)
                        report_mismatch($sformatf("result %0d out_value %0d, expected %0d",
                                                  results_seen, res_if.out_value,
                                                  want.out_value));
                    if (res_if.frame_last !== want.frame_last)
                        report_mismatch($sformatf("result %0d frame_last %0b, expected %0b",
                                                  results_seen, res_if.frame_last,
                                                  want.frame_last));
                end
                results_seen++;
            end
            if (cfg_if.valid && cfg_if.ready) apply_register_write(cfg_if.index, cfg_if.data);
            if (pix_if.valid && pix_if.ready) predict_output_pixel(pix_if.mode, pix_if.pixel_value);
        end
    end

    initial begin : stimulus
        int k, w, h, set_pct, frames, f, cut, start_items;
        logic op;
        i_rst_n            = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_OPERATION;
        cfg_if.data        = '0;
        cfg_op             = OP_ERODE;
        cfg_width          = CFG_DATA_W'(DIM_RESET);
        cfg_height         = CFG_DATA_W'(DIM_RESET);
        restart_positions();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the frame is 4096 by 4096, so these pixels release nothing.
        push_item(MODE_PIXEL, PIX_SET);
        push_item(MODE_PIXEL, 8'h01);
        wait_idle();

        // Single column: every pixel reads back the line memory column just written.
        write_reg(REG_OPERATION, CFG_DATA_W'(OP_DILATE));
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd9);
        queue_frame(1, 9, 30, 1'b0, 1'b0);
        wait_idle();

        // Single row: a zero height is read as one row.
        write_reg(REG_IMAGE_WIDTH, 13'd7);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        queue_frame(7, 1, 20, 1'b0, 1'b0);
        wait_idle();

        // Small erosion frame; a write to the spare index part-way must not restart it.
        write_reg(REG_OPERATION, CFG_DATA_W'(OP_ERODE));
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        push_item(MODE_PIXEL, PIX_SET);
        push_item(MODE_PIXEL, 8'h01);
        push_item(MODE_PIXEL, 8'h80);
        push_item(MODE_PIXEL, 8'h02);
        wait_idle();
        write_reg(REG_SPARE, 13'h1FFF);
        push_item(MODE_PIXEL, PIX_SET);
        push_item(MODE_DRAIN, PIX_SET);
        push_item(MODE_PIXEL, 8'h40);
        push_item(MODE_PIXEL, PIX_SET);
        push_item(MODE_PIXEL, PIX_SET);
        push_item(MODE_PIXEL, PIX_CLEAR);
        push_item(MODE_DRAIN, PIX_CLEAR);
        push_item(MODE_DRAIN, PIX_CLEAR);
        push_item(MODE_DRAIN, PIX_CLEAR);
        push_item(MODE_PIXEL, PIX_CLEAR);
        wait_idle();

        // Dilation of a single set corner pixel in a two-row frame.
        write_reg(REG_OPERATION, CFG_DATA_W'(OP_DILATE));
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        for (k = 0; k < 5; k++) push_item(MODE_PIXEL, PIX_CLEAR);
        push_item(MODE_PIXEL, PIX_SET);
        for (k = 0; k < 4; k++) push_item(MODE_DRAIN, PIX_CLEAR);
        wait_idle();

        // One-pixel frames from zero width and height; the second is flushed by a pixel.
        write_reg(REG_OPERATION, CFG_DATA_W'(OP_ERODE));
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        push_item(MODE_PIXEL, PIX_SET);
        push_item(MODE_DRAIN, PIX_CLEAR);
        push_item(MODE_PIXEL, PIX_CLEAR);
        push_item(MODE_PIXEL, 8'h07);
        wait_idle();

        start_items = stream_items;

        // The sender pauses until the core is empty, then the receiver holds off for a long
        // stretch while the rest of the frame is offered, so the core fills and stalls.
        write_reg(REG_OPERATION, CFG_DATA_W'(OP_DILATE));
        write_reg(REG_IMAGE_WIDTH, 13'd5);
        write_reg(REG_IMAGE_HEIGHT, 13'd6);
        queue_frame(5, 6, 30, 1'b1, 1'b1);
        wait_idle();

        while (stream_items - start_items < RANDOM_ITEMS) begin
            if (stream_items - start_items > RANDOM_ITEMS - 60) no_idle = 1'b1;
            op = ($urandom_range(0, 1) == 1) ? OP_DILATE : OP_ERODE;
            w  = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            h  = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            write_reg(REG_OPERATION, CFG_DATA_W'(op));
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            if ($urandom_range(0, 3) == 0) set_pct = 50;
            else set_pct = (op == OP_DILATE) ? 15 : 85;
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Frame cut short; the next register write restarts it.
                    cut = $urandom_range(1, w * h);
                    for (k = 0; k < cut; k++) push_item(MODE_PIXEL, draw_mask_byte(set_pct));
                    stream_items += cut;
                    break;
                end
                queue_frame(w, h, set_pct, $urandom_range(0, 11) == 0, 1'b0);
            end
            wait_idle();
        end

        no_idle = 1'b1;
        while (pixels_to_send.size() != 0 || pix_if.valid) @(posedge i_clk);
        for (k = 0; k < DRAIN_LIMIT && expected_out_pixels.size() != 0; k++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_out_pixels.size() != 0)
            report_mismatch($sformatf("%0d expected output pixels never arrived",
                                      expected_out_pixels.size()));
        if (mismatch_count == 0) begin
            $display("binary_morphology_3x3_core verification clean");
        end else begin
            $display("binary_morphology_3x3_core verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bm3_pkg.sv
rtl/core/bm3_if.sv
rtl/core/bm3_line_buf.sv
rtl/core/bm3_out_fifo.sv
rtl/core/binary_morphology_3x3_core.sv
tb/sv/binary_morphology_3x3_core_tb.sv
